/* rtl/hsv2rgb_pkg.sv */
// ----------------------------------------------------------------------------
// hsv2rgb_pkg
// shared types and constants for the hsv to rgb colour converter
// ----------------------------------------------------------------------------
package hsv2rgb_pkg;

  // pipeline depth: hue split, fraction, blend factors, channel products
  localparam int unsigned NumStages = 4;

  localparam logic [15:0] HueFull   = 16'd23040;  // 360 degrees in 1/64 units
  localparam logic [14:0] HueSector = 15'd3840;   // 60 degrees in 1/64 units
  localparam logic [11:0] FracRecip = 12'd2185;   // ceil(2^15 / 15)
  localparam int unsigned FracShift = 15;
  localparam logic [8:0]  QOne      = 9'd256;     // 1.0 in q1.8

  // colour wheel sector
  typedef enum logic [2:0] {
    SEC_R_TO_Y = 3'd0,
    SEC_Y_TO_G = 3'd1,
    SEC_G_TO_C = 3'd2,
    SEC_C_TO_B = 3'd3,
    SEC_B_TO_M = 3'd4,
    SEC_M_TO_R = 3'd5
  } sector_e;

  // stage load enables for a two stage module
  typedef struct packed {
    logic first;
    logic second;
  } stage_en_t;

  // word passed from the hue split to the channel mixer
  typedef struct packed {
    sector_e    sector;
    logic [7:0] frac;
    logic [8:0] sat;
    logic [8:0] val;
  } frac_word_t;

endpackage

/* rtl/hsv2rgb_sector.sv */
// ----------------------------------------------------------------------------
// hsv2rgb_sector
// hue wrap, sector split and fraction, with clamped saturation and value
// ----------------------------------------------------------------------------
module hsv2rgb_sector (
  input  logic                    clk_i,
  input  hsv2rgb_pkg::stage_en_t  en_i,
  input  logic [15:0]             hue_deg_i,
  input  logic [8:0]              saturation_i,
  input  logic [8:0]              brightness_i,
  output hsv2rgb_pkg::frac_word_t word_o
);
  import hsv2rgb_pkg::*;

  logic [14:0] hue_w;
  logic [14:0] base_w;
  logic [14:0] rem_w;
  sector_e     sector_w;

  sector_e     sector_a_q;
  logic [11:0] rem_a_q;
  logic [8:0]  sat_a_q;
  logic [8:0]  val_a_q;

  logic [23:0] frac_prod_w;
  frac_word_t  word_q;

  // a hue of a full turn or more counts as zero
  assign hue_w = (hue_deg_i >= HueFull) ? 15'd0 : hue_deg_i[14:0];

  always_comb begin
    sector_w = SEC_R_TO_Y;
    base_w   = 15'd0;
    if (hue_w >= 15'(HueSector * 5)) begin
      sector_w = SEC_M_TO_R;
      base_w   = 15'(HueSector * 5);
    end else if (hue_w >= 15'(HueSector * 4)) begin
      sector_w = SEC_B_TO_M;
      base_w   = 15'(HueSector * 4);
    end else if (hue_w >= 15'(HueSector * 3)) begin
      sector_w = SEC_C_TO_B;
      base_w   = 15'(HueSector * 3);
    end else if (hue_w >= 15'(HueSector * 2)) begin
      sector_w = SEC_G_TO_C;
      base_w   = 15'(HueSector * 2);
    end else if (hue_w >= HueSector) begin
      sector_w = SEC_Y_TO_G;
      base_w   = HueSector;
    end
  end

  assign rem_w = hue_w - base_w;

  always_ff @(posedge clk_i) begin
    if (en_i.first) begin
      sector_a_q <= sector_w;
      rem_a_q    <= rem_w[11:0];
      sat_a_q    <= (saturation_i > QOne) ? QOne : saturation_i;
      val_a_q    <= (brightness_i > QOne) ? QOne : brightness_i;
    end
  end

  // remainder / 15 by reciprocal, exact for remainders below 3840
  assign frac_prod_w = 24'(rem_a_q) * 24'(FracRecip);

  always_ff @(posedge clk_i) begin
    if (en_i.second) begin
      word_q.sector <= sector_a_q;
      word_q.frac   <= frac_prod_w[FracShift+7:FracShift];
      word_q.sat    <= sat_a_q;
      word_q.val    <= val_a_q;
    end
  end

  assign word_o = word_q;

endmodule

/* rtl/hsv2rgb_mix.sv */
// ----------------------------------------------------------------------------
// hsv2rgb_mix
// blend factors, p q t products and sector channel select
// ----------------------------------------------------------------------------
module hsv2rgb_mix (
  input  logic                    clk_i,
  input  hsv2rgb_pkg::stage_en_t  en_i,
  input  hsv2rgb_pkg::frac_word_t word_i,
  output logic [8:0]              red_o,
  output logic [8:0]              green_o,
  output logic [8:0]              blue_o
);
  import hsv2rgb_pkg::*;

  logic [8:0]  one_minus_f_w;
  logic [16:0] sf_prod_w;
  logic [16:0] st_prod_w;

  sector_e     sector_c_q;
  logic [8:0]  val_c_q;
  logic [8:0]  oms_c_q;   // 1 - s
  logic [7:0]  sf_c_q;    // s * f
  logic [8:0]  st_c_q;    // s * (1 - f)

  logic [16:0] p_prod_w;
  logic [16:0] q_prod_w;
  logic [16:0] t_prod_w;
  logic [8:0]  p_w;
  logic [8:0]  q_w;
  logic [8:0]  t_w;
  logic [8:0]  red_d;
  logic [8:0]  green_d;
  logic [8:0]  blue_d;
  logic [8:0]  red_q;
  logic [8:0]  green_q;
  logic [8:0]  blue_q;

  assign one_minus_f_w = QOne - {1'b0, word_i.frac};
  assign sf_prod_w     = 17'(word_i.sat) * 17'(word_i.frac);
  assign st_prod_w     = 17'(word_i.sat) * 17'(one_minus_f_w);

  always_ff @(posedge clk_i) begin
    if (en_i.first) begin
      sector_c_q <= word_i.sector;
      val_c_q    <= word_i.val;
      oms_c_q    <= QOne - word_i.sat;
      sf_c_q     <= sf_prod_w[15:8];
      st_c_q     <= st_prod_w[16:8];
    end
  end

  assign p_prod_w = 17'(val_c_q) * 17'(oms_c_q);
  assign q_prod_w = 17'(val_c_q) * 17'(QOne - {1'b0, sf_c_q});
  assign t_prod_w = 17'(val_c_q) * 17'(QOne - st_c_q);
  assign p_w      = p_prod_w[16:8];
  assign q_w      = q_prod_w[16:8];
  assign t_w      = t_prod_w[16:8];

  always_comb begin
    case (sector_c_q)
      SEC_R_TO_Y: begin
        red_d = val_c_q; green_d = t_w;     blue_d = p_w;
      end
      SEC_Y_TO_G: begin
        red_d = q_w;     green_d = val_c_q; blue_d = p_w;
      end
      SEC_G_TO_C: begin
        red_d = p_w;     green_d = val_c_q; blue_d = t_w;
      end
      SEC_C_TO_B: begin
        red_d = p_w;     green_d = q_w;     blue_d = val_c_q;
      end
      SEC_B_TO_M: begin
        red_d = t_w;     green_d = p_w;     blue_d = val_c_q;
      end
      default: begin
        red_d = val_c_q; green_d = p_w;     blue_d = q_w;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en_i.second) begin
      red_q   <= red_d;
      green_q <= green_d;
      blue_q  <= blue_d;
    end
  end

  assign red_o   = red_q;
  assign green_o = green_q;
  assign blue_o  = blue_q;

endmodule

/* rtl/hsv_to_rgb_converter.sv */
// ----------------------------------------------------------------------------
// hsv_to_rgb_converter
// fixed point hsv to rgb colour conversion; while the output keeps up, one word per clock
// ----------------------------------------------------------------------------
// Takes one colour per word (hue in 1/64 degree units, saturation and value
// in q1.8 where 256 is 1.0) and returns red, green and blue in q1.8. Hue of
// 360 degrees or more counts as zero; saturation and value above 1.0 are
// clamped to 1.0, and zero saturation gives grey. The block accepts one word
// every clock cycle unless the output stalls, and each word passes through
// the four register stages (hue split, fraction multiply, blend factor
// multiplies, channel multiplies with select), each holding one word, and a
// stage takes a new word whenever it is empty or its contents move on, so a
// stall at the output only blocks the input once every stage is full.
// ----------------------------------------------------------------------------
module hsv_to_rgb_converter (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input words
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [39:0] s_axis_tdata_i,   // hue_deg[15:0], saturation[24:16],
                                        // brightness[33:25], zero fill
  // output words
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [31:0] m_axis_tdata_o    // red[8:0], green[17:9], blue[26:18],
                                        // zero fill
);
  import hsv2rgb_pkg::*;

  logic [NumStages-1:0] valid_q;
  logic [NumStages-1:0] valid_d;
  logic [NumStages-1:0] ready_w;

  stage_en_t  split_en_w;
  stage_en_t  mix_en_w;
  frac_word_t frac_word_w;
  logic [8:0] red_w;
  logic [8:0] green_w;
  logic [8:0] blue_w;

  // a stage can load when it is empty or the stage after it moves on
  always_comb begin
    ready_w[NumStages-1] = !valid_q[NumStages-1] || m_axis_tready_i;
    for (int k = NumStages - 2; k >= 0; k--) begin
      ready_w[k] = !valid_q[k] || ready_w[k+1];
    end
  end

  // valid bits follow the data through the stages
  always_comb begin
    valid_d[0] = ready_w[0] ? s_axis_tvalid_i : valid_q[0];
    for (int k = 1; k < NumStages; k++) begin
      valid_d[k] = ready_w[k] ? valid_q[k-1] : valid_q[k];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  assign split_en_w.first  = ready_w[0];
  assign split_en_w.second = ready_w[1];
  assign mix_en_w.first    = ready_w[2];
  assign mix_en_w.second   = ready_w[3];

  // stages one and two: hue split and fraction
  hsv2rgb_sector u_sector (
    .clk_i        (clk_i),
    .en_i         (split_en_w),
    .hue_deg_i    (s_axis_tdata_i[15:0]),
    .saturation_i (s_axis_tdata_i[24:16]),
    .brightness_i (s_axis_tdata_i[33:25]),
    .word_o       (frac_word_w)
  );

  // stages three and four: blend factors and channel products
  hsv2rgb_mix u_mix (
    .clk_i   (clk_i),
    .en_i    (mix_en_w),
    .word_i  (frac_word_w),
    .red_o   (red_w),
    .green_o (green_w),
    .blue_o  (blue_w)
  );

  assign s_axis_tready_o = ready_w[0];
  assign m_axis_tvalid_o = valid_q[NumStages-1];
  assign m_axis_tdata_o  = {5'd0, blue_w, green_w, red_w};

  // input only backs up once every stage holds a word
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready_o |-> (&valid_q))
    else $error("input stalled with an empty stage");

  // a word in stage one moves into stage two when that stage can load
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q[0] && ready_w[1]) |=> valid_q[1])
    else $error("word lost between stage one and stage two");

  // every delivered channel lies within 0..1.0
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (red_w <= QOne && green_w <= QOne && blue_w <= QOne))
    else $error("output channel above full intensity");

endmodule

/* tb/tb_hsv_to_rgb_converter.sv */
// ----------------------------------------------------------------------------
// tb_hsv_to_rgb_converter
// self-checking bench for the hsv to rgb colour converter
// ----------------------------------------------------------------------------
// Drives colour words into the slave stream and collects rgb words from the
// master stream. A scoreboard works out the expected rgb for every accepted
// colour and checks each returned word against the oldest one in order.
// A short directed set comes first: hue wrap, sector edges, grey and the
// clamped saturation and value. Random colours follow in three phases of
// handshake idling. One long receiver hold-off fills the pipeline so that
// the input stalls.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_hsv_to_rgb_converter;
  import hsv2rgb_pkg::*;

  typedef struct packed {
    logic [8:0] red;
    logic [8:0] green;
    logic [8:0] blue;
  } rgb_t;

  class colour_scoreboard;
    rgb_t        rgb_q[$];
    int unsigned mismatches = 0;

    // one line per mismatch
    task report_mismatch(string msg);
      mismatches++;
      $display("[%0t] mismatch: %s", $realtime, msg);
    endtask

    // expected rgb for one colour word
    function rgb_t rgb_from_hsv(logic [39:0] word);
      logic [15:0] hue;
      logic [8:0]  sat, bri;
      sector_e     sector;
      logic [7:0]  frac;
      logic [17:0] sat_f, sat_nf;
      logic [8:0]  p, q, t;
      rgb_t        rgb;
      hue = word[15:0];
      sat = (word[24:16] > QOne) ? QOne : word[24:16];
      bri = (word[33:25] > QOne) ? QOne : word[33:25];
      if (sat == 9'd0) begin
        rgb = '{red: bri, green: bri, blue: bri};
      end else begin
        if (hue >= HueFull) hue = 16'd0;
        sector = sector_e'(3'(hue / HueSector));
        frac   = 8'((hue % HueSector) / 16'd15);
        sat_f  = (18'(sat) * 18'(frac)) >> 8;
        sat_nf = (18'(sat) * (18'(QOne) - 18'(frac))) >> 8;
        p = 9'((18'(bri) * (18'(QOne) - 18'(sat))) >> 8);
        q = 9'((18'(bri) * (18'(QOne) - sat_f)) >> 8);
        t = 9'((18'(bri) * (18'(QOne) - sat_nf)) >> 8);
        case (sector)
          SEC_R_TO_Y: rgb = '{red: bri, green: t,   blue: p};
          SEC_Y_TO_G: rgb = '{red: q,   green: bri, blue: p};
          SEC_G_TO_C: rgb = '{red: p,   green: bri, blue: t};
          SEC_C_TO_B: rgb = '{red: p,   green: q,   blue: bri};
          SEC_B_TO_M: rgb = '{red: t,   green: p,   blue: bri};
          default:    rgb = '{red: bri, green: p,   blue: q};
        endcase
      end
      return rgb;
    endfunction

    function void note_colour(logic [39:0] word);
      rgb_q = {rgb_q, rgb_from_hsv(word)};
    endfunction

    task check_rgb(logic [31:0] word);
      rgb_t want;
      if (rgb_q.size() == 0) begin
        report_mismatch($sformatf("unexpected rgb word %h", word));
      end else begin
        want = rgb_q.pop_front();
        if (word[8:0] !== want.red)
          report_mismatch($sformatf("red %0d, want %0d", word[8:0], want.red));
        if (word[17:9] !== want.green)
          report_mismatch($sformatf("green %0d, want %0d", word[17:9], want.green));
        if (word[26:18] !== want.blue)
          report_mismatch($sformatf("blue %0d, want %0d", word[26:18], want.blue));
      end
    endtask

    function int unsigned pending();
      return rgb_q.size();
    endfunction
  endclass

  localparam int unsigned ClkHalf      = 4;      // 8 ns period
  localparam int unsigned NumDirected  = 23;
  localparam int unsigned RandPerPhase = 645;
  localparam int unsigned HoldAt       = NumDirected + 2 * RandPerPhase + 60;
  localparam int unsigned HoldCycles   = 120;
  localparam int unsigned LimitNs      = 2_000_000;

  logic        clk_i   = 1'b0;
  logic        rst_ni  = 1'b0;
  logic        s_valid = 1'b0;
  logic [39:0] s_data  = '0;      // hue_deg[15:0], saturation[24:16],
                                  // brightness[33:25], zero fill
  logic        s_ready;
  logic        m_valid;
  logic        m_ready = 1'b0;
  logic [31:0] m_data;            // red[8:0], green[17:9], blue[26:18], zero fill

  // idling odds in percent, set per phase by the main sequence
  int unsigned src_idle_pct  = 0;
  int unsigned sink_idle_pct = 0;
  int unsigned words_sent    = 0;

  colour_scoreboard sb = new();

  always #(ClkHalf) clk_i = ~clk_i;

  hsv_to_rgb_converter uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_ready),
    .s_axis_tdata_i  (s_data),
    .m_axis_tvalid_o (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_data)
  );

  // both handshakes are sampled at the rising edge
  always @(posedge clk_i) begin
    if (rst_ni && s_valid && s_ready) sb.note_colour(s_data);
    if (rst_ni && m_valid && m_ready) sb.check_rgb(m_data);
  end

  // receiver: random stalls, plus one long hold-off once the stream is busy
  initial begin
    int unsigned hold_left;
    bit          hold_done;
    hold_left = 0;
    hold_done = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_left > 0) begin
        hold_left--;
        m_ready <= 1'b0;
      end else if (!hold_done && words_sent >= HoldAt) begin
        // sender keeps offering, so every stage fills and tready drops
        hold_done = 1'b1;
        hold_left = HoldCycles - 1;
        m_ready <= 1'b0;
      end else begin
        m_ready <= ($urandom_range(99) >= sink_idle_pct);
      end
    end
  end

  // offer one colour word, called at a falling edge, returns at a falling edge
  task send_colour(logic [15:0] hue, logic [8:0] sat, logic [8:0] bri);
    if ($urandom_range(99) < src_idle_pct) begin
      s_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk_i);
    end
    s_valid <= 1'b1;
    s_data  <= {6'd0, bri, sat, hue};
    do @(posedge clk_i); while (!s_ready);
    @(negedge clk_i);
    words_sent++;
  endtask

  // hue mostly on the wheel, some wrapped, some hugging sector edges
  function logic [15:0] rand_hue();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 70) return 16'($urandom_range(23039));
    if (pick < 85) return 16'($urandom_range(65535, 23040));
    return 16'(int'($urandom_range(6)) * 3840 + int'($urandom_range(4)) - 2);
  endfunction

  // q1.8 level with zero, one and over-range all showing up
  function logic [8:0] rand_level();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 10) return 9'd0;
    if (pick < 20) return 9'd256;
    if (pick < 30) return 9'($urandom_range(511, 257));
    return 9'($urandom_range(256));
  endfunction

  initial begin
    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    src_idle_pct  = 14;
    sink_idle_pct = 61;

    // hue wrap at and above 360 degrees
    send_colour(16'd0,     9'd256, 9'd256);
    send_colour(16'd23039, 9'd256, 9'd256);
    send_colour(16'd23040, 9'd256, 9'd256);
    send_colour(16'd23041, 9'd100, 9'd100);
    send_colour(16'd65535, 9'd256, 9'd256);
    // each sector start
    send_colour(16'd3840,  9'd256, 9'd256);
    send_colour(16'd7680,  9'd256, 9'd256);
    send_colour(16'd11520, 9'd256, 9'd256);
    send_colour(16'd15360, 9'd256, 9'd256);
    send_colour(16'd19200, 9'd256, 9'd256);
    // fraction edges within a sector
    send_colour(16'd3839,  9'd128, 9'd200);
    send_colour(16'd14,    9'd256, 9'd256);
    send_colour(16'd15,    9'd256, 9'd256);
    // grey, with and without the value clamp
    send_colour(16'd0,     9'd0,   9'd200);
    send_colour(16'd12345, 9'd0,   9'd511);
    send_colour(16'd40000, 9'd0,   9'd0);
    // saturation and value above one
    send_colour(16'd5000,  9'd511, 9'd300);
    send_colour(16'd20000, 9'd257, 9'd257);
    send_colour(16'd65535, 9'd511, 9'd511);
    send_colour(16'd17000, 9'd384, 9'd170);
    // dark and faint corners
    send_colour(16'd9000,  9'd256, 9'd0);
    send_colour(16'd1000,  9'd1,   9'd1);
    send_colour(16'd22000, 9'd255, 9'd255);

    repeat (RandPerPhase) send_colour(rand_hue(), rand_level(), rand_level());

    src_idle_pct  = 61;
    sink_idle_pct = 14;
    repeat (RandPerPhase) send_colour(rand_hue(), rand_level(), rand_level());

    // full rate both ways, the long hold-off lands in here
    src_idle_pct  = 0;
    sink_idle_pct = 0;
    repeat (RandPerPhase) send_colour(rand_hue(), rand_level(), rand_level());
    s_valid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk_i);
    // catch any stray word after the last expected one
    repeat (NumStages * 4) @(posedge clk_i);

    if (sb.mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // watchdog
  initial begin
    #(LimitNs);
    $display("[%0t] timeout, %0d rgb words outstanding", $realtime, sb.pending());
    $display("*** FAILED ***");
    $finish;
  end

endmodule
